// File: src/sync_length_crc_frame_receiver_top_macros.svh
// Assertion macros for the frame parser module.
// No dependencies; included by slcr_deframe, the file that carries assertions.
`ifndef SYNC_LENGTH_CRC_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LENGTH_CRC_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SLCR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frame receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SLCR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frame receiver: next-cycle check failed");

`endif

// File: src/slcr_pkg.sv
// Types and constants of the sync/length/CRC frame receiver.
// No dependencies; imported by every module of the block.
package slcr_pkg;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_OVERFLOW = 2'd3
    } slcr_status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Frame offsets, sync bytes included
    localparam int POS_HUNT      = 0;
    localparam int POS_SYNC2     = 1;
    localparam int POS_LEN_HI    = 2;
    localparam int POS_LEN_LO    = 3;
    localparam int POS_TYPE      = 4;
    localparam int PAYLOAD_START = 5;

    // Live configuration
    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_payload;
    } slcr_cfg_t;

    // One result transaction
    typedef struct packed {
        logic         payload_valid;
        logic [7:0]   payload_byte;
        logic         frame_done;
        slcr_status_t frame_status;
        logic [7:0]   frame_type;
        logic [15:0]  frame_length;
    } slcr_result_t;

endpackage

// File: src/slcr_crc_byte.sv
// One-byte update of CRC-16/CCITT-FALSE, MSB first, as an XOR network.
// Depends on slcr_pkg for the polynomial.
module slcr_crc_byte
    import slcr_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    // Shift eight bits through the polynomial
    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// File: src/slcr_cfg_regs.sv
// Configuration registers: sync bytes and payload length limit.
// Depends on slcr_pkg for register indexes, reset values and slcr_cfg_t.
module slcr_cfg_regs
    import slcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output slcr_cfg_t   cfg
);

    slcr_cfg_t cfg_reg;
    slcr_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    // Decode the write; drop indexes beyond the list
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg_data[7:0];
                CFG_SYNC_SECOND: cfg_next.sync_second = cfg_data[7:0];
                CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.max_payload <= MAX_PAYLOAD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/slcr_deframe.sv
// Frame parser: sync hunt, header, payload, CRC check and result register.
// Depends on slcr_pkg, slcr_crc_byte and the assertion macro header.
`include "sync_length_crc_frame_receiver_top_macros.svh"

module slcr_deframe
    import slcr_pkg::*;
#(
    parameter int BUF_BYTES = 2048
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  slcr_cfg_t    cfg,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_in_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output slcr_result_t m_result
);

    localparam int PW   = $clog2(BUF_BYTES + 1);
    localparam int CMPW = (PW > 17) ? PW : 17;

    // Frame state
    logic [PW-1:0] pos_reg, pos_next;
    logic [15:0]   len_reg, len_next;
    logic [7:0]    type_reg, type_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    crc_hi_reg, crc_hi_next;

    // Result register
    logic          m_valid_reg, m_valid_next;
    slcr_result_t  rslt_reg, rslt_next;

    logic          s_accept;
    logic [15:0]   crc_upd;
    logic [15:0]   len_lo;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] pay_end;

    slcr_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (s_in_byte),
        .crc_out (crc_upd)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = rslt_reg;

    assign len_lo  = {len_reg[15:8], s_in_byte};
    assign pos_ext = CMPW'(pos_reg);
    assign pay_end = CMPW'(len_reg) + CMPW'(PAYLOAD_START);

    // Advance the parser by one byte
    always_comb begin
        logic clear;
        clear       = 1'b0;
        pos_next    = pos_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        rslt_next   = '0;

        if (pos_reg == PW'(POS_HUNT)) begin
            if (s_in_byte == cfg.sync_first) begin
                pos_next = PW'(POS_SYNC2);
            end
        end else if (pos_reg == PW'(POS_SYNC2)) begin
            if (s_in_byte == cfg.sync_second) begin
                pos_next = PW'(POS_LEN_HI);
            end else if (s_in_byte == cfg.sync_first) begin
                pos_next = PW'(POS_SYNC2);
            end else begin
                pos_next = PW'(POS_HUNT);
            end
        end else if (pos_reg >= PW'(BUF_BYTES)) begin
            // Drop the byte: it would run past the buffer
            rslt_next.frame_done   = 1'b1;
            rslt_next.frame_status = ST_OVERFLOW;
            rslt_next.frame_type   = type_reg;
            rslt_next.frame_length = len_reg;
            clear = 1'b1;
        end else begin
            pos_next = PW'(pos_reg + 1'b1);
            if (pos_reg == PW'(POS_LEN_HI)) begin
                len_next = {s_in_byte, 8'h00};
            end else if (pos_reg == PW'(POS_LEN_LO)) begin
                len_next = len_lo;
                if (len_lo > cfg.max_payload) begin
                    rslt_next.frame_done   = 1'b1;
                    rslt_next.frame_status = ST_TOO_LONG;
                    rslt_next.frame_type   = type_reg;
                    rslt_next.frame_length = len_lo;
                    clear = 1'b1;
                end
            end else if (pos_reg == PW'(POS_TYPE)) begin
                type_next = s_in_byte;
                crc_next  = crc_upd;
            end else if (pos_ext < pay_end) begin
                crc_next                = crc_upd;
                rslt_next.payload_valid = 1'b1;
                rslt_next.payload_byte  = s_in_byte;
            end else if (pos_ext == pay_end) begin
                crc_hi_next = s_in_byte;
            end else begin
                rslt_next.frame_done   = 1'b1;
                rslt_next.frame_status = ({crc_hi_reg, s_in_byte} == crc_reg)
                                         ? ST_GOOD : ST_CRC_ERR;
                rslt_next.frame_type   = type_reg;
                rslt_next.frame_length = len_reg;
                clear = 1'b1;
            end
        end

        // Restart the hunt after a done result
        if (clear) begin
            pos_next    = PW'(POS_HUNT);
            len_next    = '0;
            type_next   = '0;
            crc_next    = CRC_INIT;
            crc_hi_next = '0;
        end
    end

    // Hold a result until the downstream side takes it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= PW'(POS_HUNT);
            len_reg     <= '0;
            type_reg    <= '0;
            crc_reg     <= CRC_INIT;
            crc_hi_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                pos_reg    <= pos_next;
                len_reg    <= len_next;
                type_reg   <= type_next;
                crc_reg    <= crc_next;
                crc_hi_reg <= crc_hi_next;
            end
        end
    end

    // Result payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rslt_reg <= rslt_next;
        end
    end

    `SLCR_ASSERT_IMP(a_pay_not_done, aclk, aresetn,
        m_valid_reg && rslt_reg.payload_valid, !rslt_reg.frame_done)
    `SLCR_ASSERT_IMP(a_idle_fields_zero, aclk, aresetn,
        m_valid_reg && !rslt_reg.frame_done,
        (rslt_reg.frame_status == ST_GOOD) && (rslt_reg.frame_length == 16'd0))
    `SLCR_ASSERT_NXT(a_done_restarts, aclk, aresetn,
        s_accept && rslt_next.frame_done, pos_reg == PW'(POS_HUNT))
    `SLCR_ASSERT_IMP(a_pos_in_buf, aclk, aresetn,
        1'b1, pos_reg <= PW'(BUF_BYTES))

endmodule

// File: src/sync_length_crc_frame_receiver_top.sv
// Top level of the sync/length/type/payload/CRC-16 frame receiver.
// Depends on slcr_pkg, slcr_cfg_regs and slcr_deframe.
//
// Usage:
//   s_valid/s_ready/s_in_byte carry one received byte per transaction.
//   m_valid/m_ready carry one result per byte: a tentative payload byte
//   (m_payload_valid), a done result with status, type and length on the
//   byte that ends or aborts a frame (m_frame_done), or neither flag. Downstream
//   keeps or drops the payload already taken according to m_frame_status.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write sync_first (0),
//   sync_second (1) and max_payload (2); cfg_ready is always high.
// Timing:
//   Each result is registered and appears in the cycle after its byte is
//   taken. One byte is taken every cycle while m_ready is high; the CRC
//   update is a one-byte XOR network feeding back into the CRC register.
// Reset (aresetn low, synchronous): the parser returns to the sync hunt,
//   the CRC to 0xFFFF, the result register empties and the registers take
//   0xAA, 0x55 and 1024.
// Stall: while a result waits with m_ready low, s_ready drops and input
//   bytes are held off; no result is lost or repeated.
module sync_length_crc_frame_receiver_top
    import slcr_pkg::*;
#(
    parameter int BUF_BYTES = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Received bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    // Results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_done,
    output logic [1:0]  m_frame_status,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_frame_length
);

    slcr_cfg_t    cfg;
    slcr_result_t result;

    slcr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slcr_deframe #(
        .BUF_BYTES (BUF_BYTES)
    ) u_deframe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (result)
    );

    // Break the result out onto its ports
    assign m_payload_valid = result.payload_valid;
    assign m_payload_byte  = result.payload_byte;
    assign m_frame_done    = result.frame_done;
    assign m_frame_status  = result.frame_status;
    assign m_frame_type    = result.frame_type;
    assign m_frame_length  = result.frame_length;

endmodule
